/* hdl/bsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

	localparam int MAX_PROCESSES = 8;
	localparam int MAX_RESOURCES = 4;
	localparam int PW = $clog2(MAX_PROCESSES);
	localparam int RW = $clog2(MAX_RESOURCES);
	localparam int AW = PW + RW;
	localparam int PCW = PW + 1;
	localparam int RCW = RW + 1;
	localparam int WORK_W = 12;
	localparam logic [WORK_W-1:0] WORK_MAX = '1;

	// item modes
	localparam logic [2:0] MODE_LOAD_AVAIL = 3'd0;
	localparam logic [2:0] MODE_LOAD_ALLOC = 3'd1;
	localparam logic [2:0] MODE_LOAD_MAX = 3'd2;
	localparam logic [2:0] MODE_REQUEST = 3'd3;
	localparam logic [2:0] MODE_CHECK = 3'd4;

	// result status codes
	localparam logic [1:0] ST_SAFE = 2'd0;
	localparam logic [1:0] ST_UNSAFE = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	// configuration register indexes
	localparam logic CFG_PROCESS_COUNT = 1'b0;
	localparam logic CFG_RESOURCE_COUNT = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REQ_RD,
		S_REQ_EV,
		S_COMMIT,
		S_INIT,
		S_P_NEXT,
		S_CHK_RD,
		S_CHK_EV,
		S_ADD,
		S_EMIT,
		S_REPORT
	} state_t;

	// one memory access port
	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [7:0]    wdata;
		logic [AW-1:0] raddr;
	} mem_port_t;

endpackage

`default_nettype wire

/* hdl/bankers_safety_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Banker's algorithm safety engine.
// Input channel (in_valid/in_stall) carries one word per item: mode selects
// load available, load allocation, load max demand, request element or
// safety check. Loads and non-final request elements produce no result, so
// they stream one word per cycle while no request or check runs.
// A final request element first checks each resource in use against need
// and available, commits the request if every check passes (else, or for
// a process out of range, it is refused), then runs the safety check. The
// safety check walks processes in passes; each unfinished process is
// selected and compared with work resource by resource, and if its need
// fits, its allocation is added to work; finished ones are skipped and a
// pass with no progress ends the check as unsafe. Resources are read one
// at a time through the single read port of the allocation and max-demand
// memories. Results leave on out_valid/out_stall: np safe-sequence words,
// one per cycle while out_stall is low, or one unsafe or refused word,
// last marking the final one. in_stall stays high while a request or
// check runs; a stalled output holds its word and the engine waits for it.
// Reset clears all stores and sets the counts to the maximum; configuration
// writes (wr_en) take effect at once.
module bankers_safety_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  wire logic       wr_index,
	input  wire logic [3:0] wr_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] mode,
	input  wire logic [2:0] process,
	input  wire logic [1:0] resource,
	input  wire logic [7:0] amount,
	input  wire logic       final_element,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      status,
	output logic [2:0]      sequence_process,
	output logic            last
);
	import bsc_pkg::*;

	logic [3:0]     pcount_q;
	logic [2:0]     rcount_q;
	logic [PCW-1:0] np;
	logic [RCW-1:0] nr;
	mem_port_t      alloc_port;
	mem_port_t      max_port;
	logic [7:0]     alloc_rd;
	logic [7:0]     max_rd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= 4'(MAX_PROCESSES);
			rcount_q <= 3'(MAX_RESOURCES);
		end else if (wr_en) begin
			if (wr_index == CFG_PROCESS_COUNT) begin
				pcount_q <= wr_data;
			end else begin
				rcount_q <= wr_data[2:0];
			end
		end
	end

	// counts in use, saturated to the supported range
	always_comb begin
		if (pcount_q == '0) begin
			np = PCW'(1);
		end else if (pcount_q > 4'(MAX_PROCESSES)) begin
			np = PCW'(MAX_PROCESSES);
		end else begin
			np = pcount_q;
		end
		if (rcount_q == '0) begin
			nr = RCW'(1);
		end else if (rcount_q > 3'(MAX_RESOURCES)) begin
			nr = RCW'(MAX_RESOURCES);
		end else begin
			nr = rcount_q;
		end
	end

	bsc_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.np               (np),
		.nr               (nr),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.mode             (mode),
		.process          (process),
		.resource         (resource),
		.amount           (amount),
		.final_element    (final_element),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.sequence_process (sequence_process),
		.last             (last),
		.alloc_port       (alloc_port),
		.max_port         (max_port),
		.alloc_rd         (alloc_rd),
		.max_rd           (max_rd)
	);

	bsc_ram #(.DEPTH(MAX_PROCESSES * MAX_RESOURCES), .WIDTH(8)) u_alloc_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (alloc_port.we),
		.waddr (alloc_port.waddr),
		.wdata (alloc_port.wdata),
		.raddr (alloc_port.raddr),
		.rdata (alloc_rd)
	);

	bsc_ram #(.DEPTH(MAX_PROCESSES * MAX_RESOURCES), .WIDTH(8)) u_max_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (max_port.we),
		.waddr (max_port.waddr),
		.wdata (max_port.wdata),
		.raddr (max_port.raddr),
		.rdata (max_rd)
	);

endmodule

`default_nettype wire

/* hdl/bsc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module bsc_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;

	// storage array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= valid_q[raddr] ? mem[raddr] : '0;
	end

	// entries read as zero until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

endmodule

`default_nettype wire

/* hdl/bsc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module bsc_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [bsc_pkg::PCW-1:0] np,
	input  wire logic [bsc_pkg::RCW-1:0] nr,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [2:0]             mode,
	input  wire logic [2:0]             process,
	input  wire logic [1:0]             resource,
	input  wire logic [7:0]             amount,
	input  wire logic                   final_element,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [1:0]                  status,
	output logic [2:0]                  sequence_process,
	output logic                        last,
	output bsc_pkg::mem_port_t          alloc_port,
	output bsc_pkg::mem_port_t          max_port,
	input  wire logic [7:0]             alloc_rd,
	input  wire logic [7:0]             max_rd
);
	import bsc_pkg::*;

	state_t state_q, state_d;

	logic [7:0]        avail_q [MAX_RESOURCES];
	logic [7:0]        reqbuf_q [MAX_RESOURCES];
	logic [7:0]        tmp_q [MAX_RESOURCES];
	logic [WORK_W-1:0] work_q [MAX_RESOURCES];
	logic [PW-1:0]     seq_q [MAX_PROCESSES];
	logic [MAX_PROCESSES-1:0] finished_q;
	logic [PW-1:0]     req_p_q;
	logic [PCW-1:0]    i_q;
	logic [PCW-1:0]    count_q;
	logic [PCW-1:0]    k_q;
	logic [RCW-1:0]    j_q;
	logic              ok_q;
	logic              fit_q;
	logic              progress_q;
	logic [1:0]        rep_status_q;

	logic              accept;
	logic              out_free;
	logic              out_load;
	logic [RW-1:0]     jx;
	logic signed [8:0] need9;
	logic signed [12:0] need13;
	logic              req_ok_now;
	logic              fit_now;
	logic              j_last;
	logic              emit_last;

	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign out_load = out_free && ((state_q == S_EMIT) || (state_q == S_REPORT));
	assign jx = j_q[RW-1:0];
	assign need9 = $signed({1'b0, max_rd}) - $signed({1'b0, alloc_rd});
	assign need13 = {{4{need9[8]}}, need9};
	assign req_ok_now = ok_q && !(need9 < $signed({1'b0, reqbuf_q[jx]}))
		&& (reqbuf_q[jx] <= avail_q[jx]);
	assign fit_now = fit_q && ($signed({1'b0, work_q[jx]}) >= need13);
	assign j_last = (j_q + RCW'(1)) >= nr;
	assign emit_last = (k_q + PCW'(1)) == np;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode == MODE_CHECK) begin
						state_d = S_INIT;
					end else if (mode == MODE_REQUEST && final_element) begin
						state_d = ({1'b0, process} < np) ? S_REQ_RD : S_REPORT;
					end
				end
			end
			S_REQ_RD: state_d = S_REQ_EV;
			S_REQ_EV: begin
				if (!j_last) begin
					state_d = S_REQ_RD;
				end else begin
					state_d = req_ok_now ? S_COMMIT : S_REPORT;
				end
			end
			S_COMMIT: state_d = j_last ? S_INIT : S_COMMIT;
			S_INIT:   state_d = S_P_NEXT;
			S_P_NEXT: begin
				if (i_q == np) begin
					if (!progress_q) begin
						state_d = S_REPORT;
					end else if (count_q == np) begin
						state_d = S_EMIT;
					end
				end else if (!finished_q[i_q[PW-1:0]]) begin
					state_d = S_CHK_RD;
				end
			end
			S_CHK_RD: state_d = S_CHK_EV;
			S_CHK_EV: begin
				if (!j_last) begin
					state_d = S_CHK_RD;
				end else begin
					state_d = fit_now ? S_ADD : S_P_NEXT;
				end
			end
			S_ADD:    state_d = S_P_NEXT;
			S_EMIT:   state_d = (out_free && emit_last) ? S_IDLE : S_EMIT;
			S_REPORT: state_d = out_free ? S_IDLE : S_REPORT;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory ports and input stall
	always_comb begin
		in_stall = (state_q != S_IDLE);
		alloc_port = '0;
		max_port = '0;
		alloc_port.raddr = (state_q == S_REQ_RD) ? {req_p_q, jx} : {i_q[PW-1:0], jx};
		max_port.raddr = alloc_port.raddr;
		case (state_q)
			S_IDLE: begin
				alloc_port.we = accept && (mode == MODE_LOAD_ALLOC);
				max_port.we = accept && (mode == MODE_LOAD_MAX);
				alloc_port.waddr = {process, resource};
				max_port.waddr = {process, resource};
				alloc_port.wdata = amount;
				max_port.wdata = amount;
			end
			S_COMMIT: begin
				alloc_port.we = 1'b1;
				alloc_port.waddr = {req_p_q, jx};
				alloc_port.wdata = tmp_q[jx] + reqbuf_q[jx];
			end
			default: begin
				alloc_port.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_RESOURCES; r++) begin
				avail_q[r] <= '0;
				reqbuf_q[r] <= '0;
				work_q[r] <= '0;
				tmp_q[r] <= '0;
			end
			for (int p = 0; p < MAX_PROCESSES; p++) begin
				seq_q[p] <= '0;
			end
			finished_q <= '0;
			req_p_q <= '0;
			i_q <= '0;
			count_q <= '0;
			k_q <= '0;
			j_q <= '0;
			ok_q <= 1'b0;
			fit_q <= 1'b0;
			progress_q <= 1'b0;
			rep_status_q <= ST_UNSAFE;
			out_valid <= 1'b0;
			status <= ST_SAFE;
			sequence_process <= '0;
			last <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mode == MODE_LOAD_AVAIL) begin
							avail_q[resource] <= amount;
						end
						if (mode == MODE_REQUEST) begin
							req_p_q <= process;
							j_q <= '0;
							ok_q <= 1'b1;
							if (final_element && ({1'b0, process} >= np)) begin
								rep_status_q <= ST_REFUSED;
								for (int r = 0; r < MAX_RESOURCES; r++) begin
									reqbuf_q[r] <= '0;
								end
							end else begin
								reqbuf_q[resource] <= amount;
							end
						end
					end
				end
				S_REQ_EV: begin
					tmp_q[jx] <= alloc_rd;
					ok_q <= req_ok_now;
					if (!j_last) begin
						j_q <= j_q + RCW'(1);
					end else begin
						j_q <= '0;
						if (!req_ok_now) begin
							rep_status_q <= ST_REFUSED;
							for (int r = 0; r < MAX_RESOURCES; r++) begin
								reqbuf_q[r] <= '0;
							end
						end
					end
				end
				S_COMMIT: begin
					avail_q[jx] <= avail_q[jx] - reqbuf_q[jx];
					j_q <= j_q + RCW'(1);
					if (j_last) begin
						for (int r = 0; r < MAX_RESOURCES; r++) begin
							reqbuf_q[r] <= '0;
						end
					end
				end
				S_INIT: begin
					for (int r = 0; r < MAX_RESOURCES; r++) begin
						work_q[r] <= {{(WORK_W-8){1'b0}}, avail_q[r]};
					end
					finished_q <= '0;
					count_q <= '0;
					i_q <= '0;
					progress_q <= 1'b0;
				end
				S_P_NEXT: begin
					if (i_q == np) begin
						if (!progress_q) begin
							rep_status_q <= ST_UNSAFE;
						end else if (count_q != np) begin
							i_q <= '0;
							progress_q <= 1'b0;
						end
						k_q <= '0;
					end else if (finished_q[i_q[PW-1:0]]) begin
						i_q <= i_q + PCW'(1);
					end else begin
						j_q <= '0;
						fit_q <= 1'b1;
					end
				end
				S_CHK_EV: begin
					tmp_q[jx] <= alloc_rd;
					fit_q <= fit_now;
					j_q <= j_q + RCW'(1);
					if (j_last && !fit_now) begin
						i_q <= i_q + PCW'(1);
					end
				end
				S_ADD: begin
					// add the finished process's allocation into work, saturating
					for (int r = 0; r < MAX_RESOURCES; r++) begin
						if (RCW'(r) < nr) begin
							if (({1'b0, work_q[r]} + {{(WORK_W-7){1'b0}}, tmp_q[r]})
								> {1'b0, WORK_MAX}) begin
								work_q[r] <= WORK_MAX;
							end else begin
								work_q[r] <= work_q[r] + {{(WORK_W-8){1'b0}}, tmp_q[r]};
							end
						end
					end
					seq_q[count_q[PW-1:0]] <= i_q[PW-1:0];
					finished_q[i_q[PW-1:0]] <= 1'b1;
					count_q <= count_q + PCW'(1);
					progress_q <= 1'b1;
					i_q <= i_q + PCW'(1);
				end
				S_EMIT: begin
					if (out_free) begin
						status <= ST_SAFE;
						sequence_process <= seq_q[k_q[PW-1:0]];
						last <= emit_last;
						k_q <= k_q + PCW'(1);
					end
				end
				S_REPORT: begin
					if (out_free) begin
						status <= rep_status_q;
						sequence_process <= '0;
						last <= 1'b1;
					end
				end
				default: begin
					j_q <= j_q;
				end
			endcase
		end
	end

	// finished flags track the sequence length
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(finished_q) == count_q))
		else $error("finished flags disagree with sequence count");

	// a process is only added while the sequence has room
	a_add_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD) |-> (count_q < np))
		else $error("sequence overflow");

	// the sequence is emitted only when complete
	a_emit_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (count_q == np))
		else $error("emitting incomplete sequence");

	// commits follow a passed request check only
	a_commit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT) |-> ok_q)
		else $error("commit without passed check");

endmodule

`default_nettype wire
